[design/lfpa_pkg.sv]
package lfpa_pkg;

   localparam int MAX_PAGES = 256;
   localparam int PAGE_W    = 8;
   localparam int COUNT_W   = $clog2(MAX_PAGES + 1);
   localparam int LINK_W    = PAGE_W + 1;
   localparam int GROW_W    = 5;
   localparam int DEPTH     = 1 << PAGE_W;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_ROOM  = 2'd1;
   localparam logic [1:0] ST_BAD_FREE = 2'd2;

   typedef struct packed {
      logic              operation;
      logic [PAGE_W-1:0] page_in;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page_out;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [PAGE_W-1:0] wr_addr;
      logic [LINK_W-1:0] wr_data;
      logic              rd_en;
      logic [PAGE_W-1:0] rd_addr;
   } link_ctl_type;

endpackage

[design/lfpa_link_store.sv]
module lfpa_link_store
   import lfpa_pkg::*;
(
   input  logic              clock,
   input  link_ctl_type      ctl,
   output logic [LINK_W-1:0] rd_data
);

   logic [LINK_W-1:0] mem [DEPTH];
   logic [LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/lifo_free_page_allocator.sv]
// channel | ports                          | word
// --------+--------------------------------+------------------------------
// request | req_valid, req_ready, req_data | operation, page_in
// result  | rsp_valid, rsp_ready, rsp_data | page_out, status
// config  | csr_we, csr_wdata              | grow_eighths
//
// A free, a bad free, or an allocate served from the lazy range or by growth
// leaves the block ready for a new request; an allocate that pops the free
// list holds off new requests while the next link is read from the link memory.
// Reset is synchronous; link memory contents are not cleared.
// A result word waits in the output register; a new request can be taken in the
// same cycle the waiting result is taken, unless a free-list pop is in progress.
module lifo_free_page_allocator
   import lfpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [GROW_W-1:0]  csr_wdata
);

   logic [GROW_W-1:0]  grow_ff;
   logic [PAGE_W-1:0]  head_ff, head_in;
   logic               nonempty_ff, nonempty_in;
   logic [COUNT_W-1:0] top_ff, top_in;
   logic [COUNT_W-1:0] low_ff, low_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   link_ctl_type       link_ctl;
   logic [LINK_W-1:0]  link_rd;

   logic               accept;
   logic [COUNT_W:0]   n_plus;
   logic [GROW_W:0]    factor;
   logic [COUNT_W+GROW_W+1:0] product;
   logic [COUNT_W+GROW_W-2:0] grown_raw;
   logic [COUNT_W-1:0] grown;
   logic [COUNT_W-1:0] top_dec, grown_dec;

   assign req_ready = !reset && !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign n_plus    = {1'b0, count_ff} + (COUNT_W+1)'(1);
   assign factor    = (GROW_W+1)'(8) + {1'b0, grow_ff};
   assign product   = (COUNT_W+GROW_W+2)'(n_plus) * (COUNT_W+GROW_W+2)'(factor);
   assign grown_raw = product[COUNT_W+GROW_W+1:3];
   assign grown     = (grown_raw > (COUNT_W+GROW_W-1)'(MAX_PAGES)) ?
                      COUNT_W'(MAX_PAGES) : grown_raw[COUNT_W-1:0];
   assign top_dec   = top_ff - COUNT_W'(1);
   assign grown_dec = grown - COUNT_W'(1);

   always_comb begin
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      top_in      = top_ff;
      low_in      = low_ff;
      count_in    = count_ff;
      busy_in     = 1'b0;
      rsp_in      = rsp_ff;
      link_ctl    = '0;
      link_ctl.wr_addr = req_data.page_in;
      link_ctl.wr_data = {nonempty_ff, head_ff};
      link_ctl.rd_addr = head_ff;

      if (busy_ff) begin
         // link of the popped page has arrived
         head_in     = link_rd[PAGE_W-1:0];
         nonempty_in = link_rd[PAGE_W];
      end else if (accept) begin
         rsp_in.page_out = '0;
         rsp_in.status   = ST_OK;
         unique case (req_data.operation)
            OP_FREE: begin
               if (req_data.page_in == '0 ||
                   COUNT_W'(req_data.page_in) >= count_ff) begin
                  rsp_in.status = ST_BAD_FREE;
               end else begin
                  link_ctl.wr_en = 1'b1;
                  head_in        = req_data.page_in;
                  nonempty_in    = 1'b1;
               end
            end
            OP_ALLOC: begin
               priority if (nonempty_ff) begin
                  link_ctl.rd_en  = 1'b1;
                  busy_in         = 1'b1;
                  rsp_in.page_out = head_ff;
               end else if (top_ff != low_ff) begin
                  top_in          = top_dec;
                  rsp_in.page_out = top_dec[PAGE_W-1:0];
               end else if (count_ff >= COUNT_W'(MAX_PAGES)) begin
                  rsp_in.status = ST_NO_ROOM;
               end else begin
                  low_in          = count_ff;
                  top_in          = grown_dec;
                  count_in        = grown;
                  rsp_in.page_out = grown_dec[PAGE_W-1:0];
               end
            end
            default: begin
               rsp_in.status = ST_OK;
            end
         endcase
      end
   end

   lfpa_link_store u_link_store (
      .clock   (clock),
      .ctl     (link_ctl),
      .rd_data (link_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grow_ff      <= GROW_W'(4);
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         top_ff       <= COUNT_W'(1);
         low_ff       <= COUNT_W'(1);
         count_ff     <= COUNT_W'(1);
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            grow_ff <= csr_wdata;
         end
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         top_ff      <= top_in;
         low_ff      <= low_in;
         count_ff    <= count_in;
         busy_ff     <= busy_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

[tb/lifo_free_page_allocator_tb.sv]
`timescale 1ns / 1ps

module lifo_free_page_allocator_tb;
   import lfpa_pkg::*;

   localparam int RUN_LIMIT = 300000;

   localparam logic NO_CSR      = 1'b0;
   localparam logic SET_CSR     = 1'b1;
   localparam logic CHECK_MODEL = 1'b0;
   localparam logic CHECK_TABLE = 1'b1;

   typedef struct packed {
      logic              set_grow;
      logic [GROW_W-1:0] grow;
      req_type           word;
      logic              typed;
      rsp_type           want;
   } dir_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we    = 1'b0;
   logic [GROW_W-1:0] csr_wdata = '0;

   // word tags seen by the scoreboard at acceptance
   logic              row_typed = CHECK_MODEL;
   rsp_type           row_want  = '0;

   int gap_pct      = 0;
   int stall_pct    = 0;
   int error_count  = 0;
   int no_room_seen = 0;
   int cycle_count  = 0;

   // allocator shadow state
   logic [GROW_W-1:0]  grow_cfg;
   logic [PAGE_W-1:0]  free_top;
   logic               free_valid;
   logic [LINK_W-1:0]  link_mem [DEPTH];
   logic [COUNT_W-1:0] lazy_top;
   logic [COUNT_W-1:0] lazy_low;
   logic [COUNT_W-1:0] page_count;

   rsp_type           answers_due [$];
   logic [PAGE_W-1:0] pages_held [$];
   logic              on_free_list [DEPTH];

   dir_row_type dir_rows [21] = '{
      {NO_CSR,  5'd0,  OP_FREE,  8'd0,   CHECK_TABLE, 8'd0, ST_BAD_FREE},
      {NO_CSR,  5'd0,  OP_FREE,  8'd255, CHECK_TABLE, 8'd0, ST_BAD_FREE},
      {NO_CSR,  5'd0,  OP_FREE,  8'd1,   CHECK_TABLE, 8'd0, ST_BAD_FREE},
      {NO_CSR,  5'd0,  OP_ALLOC, 8'd0,   CHECK_TABLE, 8'd2, ST_OK},
      {NO_CSR,  5'd0,  OP_ALLOC, 8'd0,   CHECK_TABLE, 8'd1, ST_OK},
      {NO_CSR,  5'd0,  OP_ALLOC, 8'd0,   CHECK_MODEL, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_FREE,  8'd2,   CHECK_TABLE, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_FREE,  8'd5,   CHECK_TABLE, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_ALLOC, 8'd0,   CHECK_MODEL, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_ALLOC, 8'd0,   CHECK_MODEL, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_FREE,  8'd6,   CHECK_TABLE, 8'd0, ST_BAD_FREE},
      {NO_CSR,  5'd0,  OP_FREE,  8'd3,   CHECK_TABLE, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_ALLOC, 8'd0,   CHECK_MODEL, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_ALLOC, 8'd0,   CHECK_MODEL, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_ALLOC, 8'd0,   CHECK_MODEL, 8'd0, ST_OK},
      {SET_CSR, 5'd31, OP_ALLOC, 8'd0,   CHECK_MODEL, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_FREE,  8'd33,  CHECK_MODEL, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_FREE,  8'd255, CHECK_TABLE, 8'd0, ST_BAD_FREE},
      {NO_CSR,  5'd0,  OP_FREE,  8'd128, CHECK_TABLE, 8'd0, ST_BAD_FREE},
      {SET_CSR, 5'd0,  OP_ALLOC, 8'd0,   CHECK_MODEL, 8'd0, ST_OK},
      {NO_CSR,  5'd0,  OP_ALLOC, 8'd255, CHECK_MODEL, 8'd0, ST_OK}
   };

   lifo_free_page_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic rsp_type page_op_answer(input req_type w);
      rsp_type     ans;
      int unsigned grown;
      ans.page_out = '0;
      ans.status   = ST_OK;
      if (w.operation == OP_FREE) begin
         if (w.page_in == '0 || w.page_in >= page_count) begin
            ans.status = ST_BAD_FREE;
         end else begin
            link_mem[w.page_in] = {free_valid, free_top};
            free_top   = w.page_in;
            free_valid = 1'b1;
         end
      end else if (free_valid) begin
         ans.page_out = free_top;
         {free_valid, free_top} = link_mem[free_top];
      end else if (lazy_top == lazy_low && page_count >= MAX_PAGES) begin
         ans.status = ST_NO_ROOM;
      end else begin
         if (lazy_top == lazy_low) begin
            grown = ((int'(page_count) + 1) * (8 + int'(grow_cfg))) >> 3;
            if (grown > MAX_PAGES) grown = MAX_PAGES;
            lazy_low   = page_count;
            lazy_top   = grown[COUNT_W-1:0];
            page_count = grown[COUNT_W-1:0];
         end
         lazy_top     = lazy_top - 1'b1;
         ans.page_out = lazy_top[PAGE_W-1:0];
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         grow_cfg   = 5'd4;
         free_top   = '0;
         free_valid = 1'b0;
         lazy_top   = COUNT_W'(1);
         lazy_low   = COUNT_W'(1);
         page_count = COUNT_W'(1);
         pages_held.delete();
         foreach (on_free_list[i]) on_free_list[i] = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("word with none due: page %0d status %0d",
                  rsp_data.page_out, rsp_data.status));
            end else begin
               due = answers_due.pop_front();
               if (rsp_data.page_out !== due.page_out)
                  report_mismatch($sformatf("page_out %0d, expected %0d",
                     rsp_data.page_out, due.page_out));
               if (rsp_data.status !== due.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                     rsp_data.status, due.status));
            end
         end
         if (csr_we) grow_cfg = csr_wdata;
         if (req_valid && req_ready) begin
            due = page_op_answer(req_data);
            if (req_data.operation == OP_FREE) begin
               if (due.status == ST_OK) begin
                  on_free_list[req_data.page_in] = 1'b1;
                  for (int i = 0; i < pages_held.size(); i++) begin
                     if (pages_held[i] == req_data.page_in) begin
                        pages_held.delete(i);
                        break;
                     end
                  end
               end
            end else if (due.status == ST_OK) begin
               on_free_list[due.page_out] = 1'b0;
               pages_held.push_back(due.page_out);
            end else begin
               no_room_seen++;
            end
            if (row_typed) due = row_want;
            answers_due.push_back(due);
         end
      end
   end

   // all driver tasks start and end just after a falling edge
   task automatic send_word(input req_type w, input logic typed, input rsp_type want);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      row_typed <= typed;
      row_want  <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_growth(input logic [GROW_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly allocs and frees of held pages; never frees a page already listed
   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      int unsigned idx;
      pick        = $urandom_range(99);
      w.operation = OP_ALLOC;
      w.page_in   = PAGE_W'($urandom_range(255));
      if (pick < 12) begin
         w.operation = OP_FREE;
         if (w.page_in != '0 && w.page_in < page_count && on_free_list[w.page_in])
            w.operation = OP_ALLOC;
      end else if (pick < 45 && pages_held.size() != 0) begin
         idx = $urandom_range(pages_held.size() - 1);
         if (!on_free_list[pages_held[idx]]) begin
            w.operation = OP_FREE;
            w.page_in   = pages_held[idx];
         end
      end
      return w;
   endfunction

   task automatic run_phase(input logic [GROW_W-1:0] grow, input int gap, input int stall,
                            input int count, input int pause_at);
      set_growth(grow);
      gap_pct   = gap;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) wait_drained();
         send_word(random_word(), CHECK_MODEL, '0);
      end
   endtask

   initial begin
      req_type           w;
      logic [PAGE_W-1:0] spare;
      int                room_base;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].set_grow) set_growth(dir_rows[i].grow);
         send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      end

      run_phase(5'd0,  0,  0,  40, -1);
      run_phase(5'd16, 83, 0,  40, -1);
      run_phase(5'd31, 0,  83, 40, 20);
      run_phase(5'd4,  15, 15, 40, -1);

      // fill to capacity, then keep asking
      w.operation = OP_ALLOC;
      room_base   = no_room_seen;
      while (no_room_seen < room_base + 3) begin
         w.page_in = PAGE_W'($urandom_range(255));
         send_word(w, CHECK_MODEL, '0);
      end
      repeat (20) send_word(random_word(), CHECK_MODEL, '0);

      // double free last: it leaves a loop in the free list
      spare = 8'd1;
      foreach (pages_held[i]) if (!on_free_list[pages_held[i]]) spare = pages_held[i];
      w.operation = OP_FREE;
      w.page_in   = spare;
      send_word(w, CHECK_MODEL, '0);
      send_word(w, CHECK_MODEL, '0);
      w.operation = OP_ALLOC;
      repeat (3) send_word(w, CHECK_MODEL, '0);

      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
